@@ src/prcc_pkg.sv @@
// ----------------------------------------------------------------------------
// prcc_pkg: shared types and constants of the poll response CRC checker
// Request and result payloads, register indexes, sequencer states and the
// command and response groups that pass between the checker's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prcc_pkg;

	// one request: a response byte or a failed reread notice
	typedef struct packed {
		logic        req_type;
		logic [15:0] dev_address;
		logic [7:0]  data_byte;
		logic        last_byte;
	} resp_in_t;

	typedef enum logic [2:0] {
		V_UNCHECKED  = 3'd0,
		V_CRC_OK     = 3'd1,
		V_REREAD_OK  = 3'd2,
		V_REREAD_REQ = 3'd3,
		V_TOO_SHORT  = 3'd4,
		V_DROPPED    = 3'd5
	} verdict_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [10:0] payload_len;
		logic        send_recovery;
		logic [31:0] checked_count;
		logic [31:0] failed_count;
		logic [31:0] recovered_count;
		logic [31:0] dropped_count;
		logic [31:0] recovery_count;
	} resp_out_t;

	// configuration register indexes
	localparam logic [1:0] REG_CRC_ENABLE    = 2'd0;
	localparam logic [1:0] REG_TRAILER_LEN   = 2'd1;
	localparam logic [1:0] REG_MAX_RETRIES   = 2'd2;
	localparam logic [1:0] REG_RECOVER_AFTER = 2'd3;

	typedef enum logic [1:0] {
		CRC_HOLD,
		CRC_INIT,
		CRC_FEED
	} crc_cmd_t;

	typedef enum logic {
		TOP_CLEAR,
		TOP_DROP
	} tbl_op_t;

	typedef struct packed {
		logic        start;
		tbl_op_t     op;
		logic [15:0] addr;
		logic [7:0]  recover_after;
	} tbl_req_t;

	typedef struct packed {
		logic done;
		logic recover;
	} tbl_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE,
		ST_DECIDE,
		ST_FIN,
		ST_CMP,
		ST_DROP,
		ST_TBL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_READ,
		T_CHECK,
		T_WRITE
	} tbl_state_t;

	typedef enum logic [1:0] {
		FK_FEED,
		FK_HI,
		FK_LO
	} fin_kind_t;

endpackage

`default_nettype wire

@@ src/prcc_crc_unit.sv @@
// ----------------------------------------------------------------------------
// prcc_crc_unit: shared CRC-16 accumulator
// Holds the running CRC-16/CCITT-FALSE value and folds in one byte per feed.
// ----------------------------------------------------------------------------
`default_nettype none

module prcc_crc_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prcc_pkg::crc_cmd_t cmd,
	input  wire logic [7:0]        din,
	output logic [15:0]            crc
);

	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	logic [15:0] crc_q;

	// MSB first, one bit per step
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
		end
		return x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_SEED;
		end else begin
			case (cmd)
				prcc_pkg::CRC_INIT: crc_q <= CRC_SEED;
				prcc_pkg::CRC_FEED: crc_q <= crc_byte(crc_q, din);
				default:            crc_q <= crc_q;
			endcase
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

@@ src/prcc_dev_table.sv @@
// ----------------------------------------------------------------------------
// prcc_dev_table: per-device drop counter table
// Walks the entries one at a time to find or allocate the device's slot,
// then clears or bumps its consecutive drop count; a drop that reaches the threshold clears it and asks for recovery.
// ----------------------------------------------------------------------------
`default_nettype none

module prcc_dev_table #(
	parameter int TABLE_ENTRIES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prcc_pkg::tbl_req_t req,
	output prcc_pkg::tbl_rsp_t     rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  drops;
	} entry_t;

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;

	prcc_pkg::tbl_state_t state_q, state_d;
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [IDX_W-1:0]         idx_q, slot_q, free_idx_q, free_slot;
	logic                     free_found_q;
	prcc_pkg::tbl_op_t        op_q;
	logic [15:0]              addr_q;
	logic [7:0]               thr_q, old_q, inc, new_drops;
	logic                     last, hit, free_here, have_free, trig, mem_we;

	assign last      = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign hit       = used_q[idx_q] && (rd_q.addr == addr_q);
	assign free_here = !used_q[idx_q];
	assign have_free = free_found_q || free_here;
	assign free_slot = free_found_q ? free_idx_q : idx_q;
	assign inc       = old_q + 8'd1;
	assign trig      = (op_q == prcc_pkg::TOP_DROP) && (inc >= thr_q);
	assign new_drops = ((op_q == prcc_pkg::TOP_DROP) && !trig) ? inc : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prcc_pkg::T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		rsp.done    = 1'b0;
		rsp.recover = 1'b0;
		mem_we      = 1'b0;
		unique case (state_q)
			prcc_pkg::T_IDLE: begin
				if (req.start) state_d = prcc_pkg::T_READ;
			end
			prcc_pkg::T_READ: begin
				state_d = prcc_pkg::T_CHECK;
			end
			prcc_pkg::T_CHECK: begin
				if (hit) begin
					state_d = prcc_pkg::T_WRITE;
				end else if (last) begin
					if (have_free) begin
						state_d = prcc_pkg::T_WRITE;
					end else begin
						// table full: no entry for this device
						rsp.done = 1'b1;
						state_d  = prcc_pkg::T_IDLE;
					end
				end else begin
					state_d = prcc_pkg::T_READ;
				end
			end
			prcc_pkg::T_WRITE: begin
				rsp.done    = 1'b1;
				rsp.recover = trig;
				mem_we      = 1'b1;
				state_d     = prcc_pkg::T_IDLE;
			end
			default: state_d = prcc_pkg::T_IDLE;
		endcase
	end

	// search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			idx_q        <= '0;
			free_found_q <= 1'b0;
		end else begin
			if (state_q == prcc_pkg::T_IDLE && req.start) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
			end
			if (state_q == prcc_pkg::T_CHECK && !hit) begin
				if (free_here) free_found_q <= 1'b1;
				if (!last) idx_q <= idx_q + 1'b1;
			end
			if (mem_we) used_q[slot_q] <= 1'b1;
		end
	end

	// request and slot payload
	always_ff @(posedge clk) begin
		if (state_q == prcc_pkg::T_IDLE && req.start) begin
			op_q   <= req.op;
			addr_q <= req.addr;
			thr_q  <= req.recover_after;
		end
		if (state_q == prcc_pkg::T_CHECK) begin
			if (hit) begin
				slot_q <= idx_q;
				old_q  <= rd_q.drops;
			end else begin
				if (free_here && !free_found_q) free_idx_q <= idx_q;
				if (last) begin
					slot_q <= free_slot;
					old_q  <= 8'd0;
				end
			end
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
		if (mem_we) mem[slot_q] <= '{addr: addr_q, drops: new_drops};
	end

endmodule

`default_nettype wire

@@ src/poll_response_crc_checker.sv @@
// ----------------------------------------------------------------------------
// poll_response_crc_checker: CRC-16 trailer check of polled device responses
// Collects response bytes, checks the CRC-16/CCITT-FALSE trailer, asks for
// rereads on a mismatch and tracks consecutive drops per device address.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction | moves
//  ---------+----------------------------------+-----------+-------------------
//  in       | in_valid, in_stall, in_data      | to block  | one byte request
//  out      | out_valid, out_stall, out_data   | from block| one verdict
//  cfg      | cfg_we, cfg_index, cfg_wdata     | to block  | one register write
//
//  A byte request that is not the last passes through a tail memory read, then
//  CRC feed and write. The last byte adds a decision state, a trailer pass
//  through the tail memory port that folds the L bytes still held (at most
//  TRAILER_MAX-2) and reads the CRC pair, then on a table update a walk over
//  the table entries, and a load of the result register.
//  Reset clears counters, registers and the table's used bits at once; the
//  tail memory and entry memory need no clearing pass.
//  in_stall is high whenever a request is in progress; a pending result that
//  out_stall holds does not block byte requests that produce no result.
//
`default_nettype none

module poll_response_crc_checker #(
	parameter int TRAILER_MAX   = 32,
	parameter int TABLE_ENTRIES = 8,
	parameter int RESPONSE_MAX  = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire prcc_pkg::resp_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output prcc_pkg::resp_out_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_wdata
);

	localparam int PTR_W = $clog2(TRAILER_MAX);
	localparam int LEN_W = $clog2(TRAILER_MAX + 1);
	localparam int CNT_W = $clog2(RESPONSE_MAX + 2);
	localparam int SUM_W = ((CNT_W > 11) ? CNT_W : 11) + 1;
	localparam logic [5:0] MIN_TRAILER = 6'd3;

	// configuration
	logic       crc_en_q;
	logic [5:0] trl_len_q;
	logic [7:0] max_retry_q, rec_after_q;

	// sequencer and response state
	prcc_pkg::state_t    state_q, state_d;
	prcc_pkg::resp_in_t  item_q;
	logic [CNT_W-1:0]    byte_cnt_q, first_len_q, len_q;
	logic [PTR_W-1:0]    wp_q, rp_q;
	logic                awaiting_q;
	logic [7:0]          attempt_q;
	logic [LEN_W-1:0]    span_q, rcnt_q;
	logic                rd_vld_s1;
	prcc_pkg::fin_kind_t rd_kind_s1;
	logic [7:0]          hi_q, lo_q;
	logic                drop_tbl_q;

	// result being built and statistics
	prcc_pkg::verdict_t  res_verdict_q;
	logic [10:0]         res_plen_q;
	logic                res_rec_q;
	logic [31:0]         checked_q, failed_q, recovered_q, dropped_q, recovery_q;
	logic                out_vld_q;
	prcc_pkg::resp_out_t out_q;

	// tail memory
	logic [7:0]       tail_mem [TRAILER_MAX];
	logic [7:0]       mem_rdata;
	logic [PTR_W-1:0] mem_raddr;
	logic             mem_we;

	// shared CRC unit and table
	prcc_pkg::crc_cmd_t crc_cmd;
	logic [7:0]         crc_din;
	logic [15:0]        crc_val;
	prcc_pkg::tbl_req_t tbl_req;
	prcc_pkg::tbl_rsp_t tbl_rsp;
	logic               tbl_start;
	prcc_pkg::tbl_op_t  tbl_op;

	logic             in_acc, load_out, byte_room, byte_old, crc_match, fin_issue;
	logic             dec_unchk, dec_over, dec_len, dec_short, n_big;
	logic [SUM_W-1:0] n_w, t_w, span_w, plen_w, clip_w;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(TRAILER_MAX - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_stall  = (state_q != prcc_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	assign byte_room = (byte_cnt_q < CNT_W'(RESPONSE_MAX));
	assign byte_old  = (SUM_W'(byte_cnt_q) >= SUM_W'(TRAILER_MAX));
	assign crc_match = (crc_val == {hi_q, lo_q});
	assign fin_issue = (rcnt_q != span_q + LEN_W'(2));

	// end-of-response decisions, in priority order
	assign n_w       = SUM_W'(byte_cnt_q);
	assign t_w       = SUM_W'(trl_len_q);
	assign dec_unchk = !crc_en_q;
	assign dec_over  = (n_w > SUM_W'(RESPONSE_MAX));
	assign dec_len   = awaiting_q && (byte_cnt_q != first_len_q);
	assign dec_short = (trl_len_q < MIN_TRAILER) || (t_w > SUM_W'(TRAILER_MAX))
	                || (n_w < t_w + SUM_W'(1));
	assign n_big     = (n_w > SUM_W'(TRAILER_MAX));
	assign span_w    = n_big ? (SUM_W'(TRAILER_MAX + 1) - t_w) : (n_w + SUM_W'(1) - t_w);
	assign plen_w    = n_w - t_w;
	assign clip_w    = dec_over ? SUM_W'(RESPONSE_MAX) : n_w;

	assign tbl_req.start         = tbl_start;
	assign tbl_req.op            = tbl_op;
	assign tbl_req.addr          = item_q.dev_address;
	assign tbl_req.recover_after = rec_after_q;

	prcc_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.din    (crc_din),
		.crc    (crc_val)
	);

	prcc_dev_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dev_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		crc_cmd   = prcc_pkg::CRC_HOLD;
		crc_din   = item_q.data_byte;
		mem_we    = 1'b0;
		mem_raddr = wp_q;
		tbl_start = 1'b0;
		tbl_op    = prcc_pkg::TOP_CLEAR;
		load_out  = 1'b0;
		unique case (state_q)
			prcc_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (!in_data.req_type) begin
						state_d = prcc_pkg::ST_BYTE;
					end else if (awaiting_q) begin
						// failed reread: discard partial bytes, drop
						crc_cmd = prcc_pkg::CRC_INIT;
						state_d = prcc_pkg::ST_DROP;
					end
				end
			end
			prcc_pkg::ST_BYTE: begin
				if (byte_room) begin
					mem_we = 1'b1;
					// fold in the byte that falls out of the tail window
					if (byte_old) begin
						crc_cmd = prcc_pkg::CRC_FEED;
						crc_din = mem_rdata;
					end
				end
				state_d = item_q.last_byte ? prcc_pkg::ST_DECIDE : prcc_pkg::ST_IDLE;
			end
			prcc_pkg::ST_DECIDE: begin
				if (dec_unchk) begin
					crc_cmd = prcc_pkg::CRC_INIT;
					state_d = prcc_pkg::ST_EMIT;
				end else if (dec_over || dec_len) begin
					crc_cmd = prcc_pkg::CRC_INIT;
					state_d = prcc_pkg::ST_DROP;
				end else if (dec_short) begin
					crc_cmd = prcc_pkg::CRC_INIT;
					state_d = awaiting_q ? prcc_pkg::ST_DROP : prcc_pkg::ST_EMIT;
				end else begin
					state_d = prcc_pkg::ST_FIN;
				end
			end
			prcc_pkg::ST_FIN: begin
				mem_raddr = rp_q;
				if (rd_vld_s1 && rd_kind_s1 == prcc_pkg::FK_FEED) begin
					crc_cmd = prcc_pkg::CRC_FEED;
					crc_din = mem_rdata;
				end
				if (rd_vld_s1 && rd_kind_s1 == prcc_pkg::FK_LO) state_d = prcc_pkg::ST_CMP;
			end
			prcc_pkg::ST_CMP: begin
				crc_cmd = prcc_pkg::CRC_INIT;
				if (crc_match) begin
					tbl_start = 1'b1;
					tbl_op    = prcc_pkg::TOP_CLEAR;
					state_d   = prcc_pkg::ST_TBL;
				end else if (attempt_q >= max_retry_q) begin
					state_d = prcc_pkg::ST_DROP;
				end else begin
					state_d = prcc_pkg::ST_EMIT;
				end
			end
			prcc_pkg::ST_DROP: begin
				if (drop_tbl_q && rec_after_q != 8'd0) begin
					tbl_start = 1'b1;
					tbl_op    = prcc_pkg::TOP_DROP;
					state_d   = prcc_pkg::ST_TBL;
				end else begin
					state_d = prcc_pkg::ST_EMIT;
				end
			end
			prcc_pkg::ST_TBL: begin
				if (tbl_rsp.done) state_d = prcc_pkg::ST_EMIT;
			end
			prcc_pkg::ST_EMIT: begin
				// hold until the result register is free
				if (!out_vld_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = prcc_pkg::ST_IDLE;
				end
			end
			default: state_d = prcc_pkg::ST_IDLE;
		endcase
	end

	// control state, configuration and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_en_q    <= 1'b0;
			trl_len_q   <= MIN_TRAILER;
			max_retry_q <= 8'd0;
			rec_after_q <= 8'd0;
			byte_cnt_q  <= '0;
			wp_q        <= '0;
			first_len_q <= '0;
			awaiting_q  <= 1'b0;
			attempt_q   <= 8'd0;
			rcnt_q      <= '0;
			rd_vld_s1   <= 1'b0;
			checked_q   <= 32'd0;
			failed_q    <= 32'd0;
			recovered_q <= 32'd0;
			dropped_q   <= 32'd0;
			recovery_q  <= 32'd0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					prcc_pkg::REG_CRC_ENABLE:    crc_en_q    <= cfg_wdata[0];
					prcc_pkg::REG_TRAILER_LEN:   trl_len_q   <= cfg_wdata[5:0];
					prcc_pkg::REG_MAX_RETRIES:   max_retry_q <= cfg_wdata;
					prcc_pkg::REG_RECOVER_AFTER: rec_after_q <= cfg_wdata;
					default: ;
				endcase
			end

			unique case (state_q)
				prcc_pkg::ST_IDLE: begin
					if (in_acc && in_data.req_type && awaiting_q) begin
						byte_cnt_q <= '0;
						wp_q       <= '0;
					end
				end
				prcc_pkg::ST_BYTE: begin
					if (byte_room) begin
						byte_cnt_q <= byte_cnt_q + 1'b1;
						wp_q       <= ptr_next(wp_q);
					end else begin
						// oversized: park the count one past the limit
						byte_cnt_q <= CNT_W'(RESPONSE_MAX + 1);
					end
				end
				prcc_pkg::ST_DECIDE: begin
					byte_cnt_q <= '0;
					wp_q       <= '0;
					if (dec_unchk) begin
						// checking off: abandon any pending reread
						awaiting_q <= 1'b0;
						attempt_q  <= 8'd0;
					end else if (dec_over || dec_len) begin
						// drop follows in its own state
					end else if (dec_short) begin
						if (!awaiting_q) dropped_q <= dropped_q + 32'd1;
					end else begin
						if (!awaiting_q) checked_q <= checked_q + 32'd1;
						rcnt_q <= '0;
					end
				end
				prcc_pkg::ST_FIN: begin
					if (fin_issue) begin
						rcnt_q    <= rcnt_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
				end
				prcc_pkg::ST_CMP: begin
					if (crc_match) begin
						if (attempt_q != 8'd0) recovered_q <= recovered_q + 32'd1;
						awaiting_q <= 1'b0;
						attempt_q  <= 8'd0;
					end else begin
						if (attempt_q == 8'd0) failed_q <= failed_q + 32'd1;
						if (attempt_q < max_retry_q) begin
							attempt_q   <= attempt_q + 8'd1;
							awaiting_q  <= 1'b1;
							first_len_q <= len_q;
						end
					end
				end
				prcc_pkg::ST_DROP: begin
					awaiting_q <= 1'b0;
					attempt_q  <= 8'd0;
					dropped_q  <= dropped_q + 32'd1;
				end
				prcc_pkg::ST_TBL: begin
					if (tbl_rsp.done && tbl_rsp.recover) recovery_q <= recovery_q + 32'd1;
				end
				prcc_pkg::ST_EMIT: ;
				default: ;
			endcase

			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			prcc_pkg::ST_IDLE: begin
				if (in_acc) item_q <= in_data;
				drop_tbl_q <= 1'b1;
			end
			prcc_pkg::ST_DECIDE: begin
				len_q      <= byte_cnt_q;
				drop_tbl_q <= awaiting_q;
				span_q     <= LEN_W'(span_w);
				rp_q       <= n_big ? wp_q : '0;
				if (dec_unchk) begin
					res_verdict_q <= prcc_pkg::V_UNCHECKED;
					res_plen_q    <= clip_w[10:0];
					res_rec_q     <= 1'b0;
				end else if (dec_short) begin
					res_verdict_q <= prcc_pkg::V_TOO_SHORT;
					res_plen_q    <= 11'd0;
					res_rec_q     <= 1'b0;
				end else begin
					res_plen_q <= plen_w[10:0];
				end
			end
			prcc_pkg::ST_FIN: begin
				if (fin_issue) begin
					rp_q <= ptr_next(rp_q);
					if (rcnt_q < span_q) begin
						rd_kind_s1 <= prcc_pkg::FK_FEED;
					end else if (rcnt_q == span_q) begin
						rd_kind_s1 <= prcc_pkg::FK_HI;
					end else begin
						rd_kind_s1 <= prcc_pkg::FK_LO;
					end
				end
				if (rd_vld_s1 && rd_kind_s1 == prcc_pkg::FK_HI) hi_q <= mem_rdata;
				if (rd_vld_s1 && rd_kind_s1 == prcc_pkg::FK_LO) lo_q <= mem_rdata;
			end
			prcc_pkg::ST_CMP: begin
				drop_tbl_q <= 1'b1;
				res_rec_q  <= 1'b0;
				if (crc_match) begin
					res_verdict_q <= awaiting_q ? prcc_pkg::V_REREAD_OK : prcc_pkg::V_CRC_OK;
				end else begin
					res_verdict_q <= prcc_pkg::V_REREAD_REQ;
					res_plen_q    <= 11'd0;
				end
			end
			prcc_pkg::ST_DROP: begin
				res_verdict_q <= prcc_pkg::V_DROPPED;
				res_plen_q    <= 11'd0;
				res_rec_q     <= 1'b0;
			end
			prcc_pkg::ST_TBL: begin
				if (tbl_rsp.done) res_rec_q <= tbl_rsp.recover;
			end
			default: ;
		endcase

		if (load_out) begin
			out_q.verdict         <= res_verdict_q;
			out_q.payload_len     <= res_plen_q;
			out_q.send_recovery   <= res_rec_q;
			out_q.checked_count   <= checked_q;
			out_q.failed_count    <= failed_q;
			out_q.recovered_count <= recovered_q;
			out_q.dropped_count   <= dropped_q;
			out_q.recovery_count  <= recovery_q;
		end
	end

	// tail memory: last TRAILER_MAX bytes of the response, registered read
	always_ff @(posedge clk) begin
		mem_rdata <= tail_mem[mem_raddr];
		if (mem_we) tail_mem[wp_q] <= item_q.data_byte;
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the poll response CRC checker
// Sends response bytes and failed reread notices, predicts each verdict and
// its counters with an in-bench model of the checker, and compares every
// verdict that the block hands out. Runs through several register settings,
// idle and stall patterns, a long receiver hold-off and oversized responses.
// ----------------------------------------------------------------------------

module tb;
	import prcc_pkg::*;

	localparam int TRAILER_MAX     = 32;
	localparam int TABLE_ENTRIES   = 8;
	localparam int RESPONSE_MAX    = 1024;
	localparam int MIN_TRAILER     = 3;
	localparam int SETTLE_CYCLES   = 80;
	localparam int HOLDOFF_CYCLES  = 400;
	localparam int WATCHDOG_CYCLES = 4000;

	// indexes of the wrapping statistics counters
	localparam int CNT_CHECKED   = 0;
	localparam int CNT_FAILED    = 1;
	localparam int CNT_RECOVERED = 2;
	localparam int CNT_DROPPED   = 3;
	localparam int CNT_RECOVERY  = 4;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	resp_in_t   in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	resp_out_t  out_data;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	poll_response_crc_checker #(
		.TRAILER_MAX(TRAILER_MAX),
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.RESPONSE_MAX(RESPONSE_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Checker model: register copies and state
	// ------------------------------------------------------------------
	bit          cfg_crc_on;
	logic [5:0]  cfg_trailer;
	logic [7:0]  cfg_retries;
	logic [7:0]  cfg_recover;

	logic [15:0] crc_run;
	logic [7:0]  tail_mem [TRAILER_MAX];
	int unsigned byte_cnt;
	int unsigned first_len;
	logic [7:0]  attempts;
	bit          reread_pending;
	bit          slot_used  [TABLE_ENTRIES];
	logic [15:0] slot_addr  [TABLE_ENTRIES];
	logic [7:0]  slot_drops [TABLE_ENTRIES];
	logic [31:0] stat_cnt   [5];

	// requests waiting to go out, and verdicts the block still owes
	resp_in_t    bytes_to_send [$];
	resp_out_t   verdicts_due  [$];

	bit          req_taken = 1'b0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          holdoff_req = 1'b0;
	int          holdoff_left = 0;
	int          quiet_cycles = 0;
	int          mismatch_count = 0;
	int          phase_items;
	int          phase_resps;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
		logic [15:0] x;
		x = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
		return x;
	endfunction

	task automatic reset_model();
		cfg_crc_on     = 1'b0;
		cfg_trailer    = 6'd3;
		cfg_retries    = '0;
		cfg_recover    = '0;
		crc_run        = 16'hFFFF;
		byte_cnt       = 0;
		first_len      = 0;
		attempts       = '0;
		reread_pending = 1'b0;
		foreach (tail_mem[i])
			tail_mem[i] = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			slot_used[i]  = 1'b0;
			slot_addr[i]  = '0;
			slot_drops[i] = '0;
		end
		foreach (stat_cnt[i])
			stat_cnt[i] = '0;
	endtask

	function automatic void restart_response();
		byte_cnt = 0;
		crc_run  = 16'hFFFF;
	endfunction

	// find the entry of an address, or claim a free one; -1 when full
	function automatic int find_slot(logic [15:0] addr);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (slot_used[i] && slot_addr[i] == addr)
				return i;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (!slot_used[i]) begin
				slot_used[i]  = 1'b1;
				slot_addr[i]  = addr;
				slot_drops[i] = '0;
				return i;
			end
		return -1;
	endfunction

	function automatic resp_out_t make_verdict(verdict_t v, int unsigned plen, bit rec);
		resp_out_t r;
		r.verdict         = v;
		r.payload_len     = 11'(plen);
		r.send_recovery   = rec;
		r.checked_count   = stat_cnt[CNT_CHECKED];
		r.failed_count    = stat_cnt[CNT_FAILED];
		r.recovered_count = stat_cnt[CNT_RECOVERED];
		r.dropped_count   = stat_cnt[CNT_DROPPED];
		r.recovery_count  = stat_cnt[CNT_RECOVERY];
		return r;
	endfunction

	// drop a response; count it against the device when the table is in use
	function automatic resp_out_t drop_verdict(logic [15:0] addr, bit use_tbl);
		bit rec;
		int s;
		rec            = 1'b0;
		reread_pending = 1'b0;
		attempts       = '0;
		stat_cnt[CNT_DROPPED]++;
		if (use_tbl && cfg_recover != 0) begin
			s = find_slot(addr);
			if (s >= 0) begin
				slot_drops[s]++;
				if (slot_drops[s] >= cfg_recover) begin
					slot_drops[s] = '0;
					rec = 1'b1;
					stat_cnt[CNT_RECOVERY]++;
				end
			end
		end
		return make_verdict(V_DROPPED, 0, rec);
	endfunction

	// advance the model by one request; return 1 when a verdict is due
	function automatic bit next_verdict(resp_in_t req, output resp_out_t res);
		logic [15:0] addr;
		logic [15:0] c;
		logic [15:0] got_crc;
		int unsigned n;
		int unsigned t;
		int unsigned first;
		int unsigned p;
		bit          retry;
		addr = req.dev_address;
		res  = '0;
		if (req.req_type) begin
			// a failed reread only matters while one is pending
			if (!reread_pending)
				return 1'b0;
			restart_response();
			res = drop_verdict(addr, 1'b1);
			return 1'b1;
		end
		if (byte_cnt < RESPONSE_MAX) begin
			p = byte_cnt % TRAILER_MAX;
			if (byte_cnt >= TRAILER_MAX)
				crc_run = crc_byte(crc_run, tail_mem[p]);
			tail_mem[p] = req.data_byte;
			byte_cnt++;
		end else begin
			byte_cnt = RESPONSE_MAX + 1;
		end
		if (!req.last_byte)
			return 1'b0;

		n     = byte_cnt;
		t     = cfg_trailer;
		retry = reread_pending;
		if (!cfg_crc_on) begin
			reread_pending = 1'b0;
			attempts       = '0;
			restart_response();
			res = make_verdict(V_UNCHECKED, (n > RESPONSE_MAX) ? RESPONSE_MAX : n, 1'b0);
			return 1'b1;
		end
		if (n > RESPONSE_MAX) begin
			restart_response();
			res = drop_verdict(addr, retry);
			return 1'b1;
		end
		if (retry && n != first_len) begin
			restart_response();
			res = drop_verdict(addr, 1'b1);
			return 1'b1;
		end
		if (t < MIN_TRAILER || t > TRAILER_MAX || n < t + 1) begin
			restart_response();
			if (retry) begin
				res = drop_verdict(addr, 1'b1);
			end else begin
				stat_cnt[CNT_DROPPED]++;
				res = make_verdict(V_TOO_SHORT, 0, 1'b0);
			end
			return 1'b1;
		end

		if (!retry)
			stat_cnt[CNT_CHECKED]++;
		// fold the bytes still held in the tail store, up to byte n-t
		c     = crc_run;
		first = (n > TRAILER_MAX) ? n - TRAILER_MAX : 0;
		for (int unsigned k = first; k <= n - t; k++)
			c = crc_byte(c, tail_mem[k % TRAILER_MAX]);
		got_crc = {tail_mem[(n - t + 1) % TRAILER_MAX], tail_mem[(n - t + 2) % TRAILER_MAX]};
		restart_response();

		if (c == got_crc) begin
			p = find_slot(addr);
			if (int'(p) >= 0)
				slot_drops[p] = '0;
			if (attempts > 0)
				stat_cnt[CNT_RECOVERED]++;
			reread_pending = 1'b0;
			attempts       = '0;
			res = make_verdict(retry ? V_REREAD_OK : V_CRC_OK, n - t, 1'b0);
			return 1'b1;
		end
		if (attempts == 0)
			stat_cnt[CNT_FAILED]++;
		if (attempts >= cfg_retries) begin
			res = drop_verdict(addr, 1'b1);
			return 1'b1;
		end
		attempts++;
		reread_pending = 1'b1;
		first_len      = n;
		res = make_verdict(V_REREAD_REQ, 0, 1'b0);
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic report_mismatch(string msg);
		// keep the log short when everything goes wrong at once
		if (mismatch_count < 40)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Request generation
	// ------------------------------------------------------------------
	task automatic push_req(logic rt, logic [15:0] addr, logic [7:0] data, logic last);
		resp_in_t r;
		r.req_type    = rt;
		r.dev_address = addr;
		r.data_byte   = data;
		r.last_byte   = last;
		bytes_to_send.push_back(r);
		if (!rt)
			phase_items++;
		if (rt || last)
			phase_resps++;
	endtask

	// n random bytes; with a usable trailer, place a matching CRC pair,
	// then flip one bit to spoil it when a bad response is wanted
	task automatic push_response(logic [15:0] addr, int n, bit good);
		logic [7:0]  body [$];
		logic [15:0] c;
		int          t;
		int          pos;
		t = cfg_trailer;
		for (int i = 0; i < n; i++)
			body.push_back(8'($urandom));
		if (t >= MIN_TRAILER && t <= TRAILER_MAX && n >= t + 1) begin
			c = 16'hFFFF;
			for (int i = 0; i <= n - t; i++)
				c = crc_byte(c, body[i]);
			body[n - t + 1] = c[15:8];
			body[n - t + 2] = c[7:0];
			if (!good) begin
				pos = $urandom_range(0, n - t + 2);
				body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		for (int i = 0; i < n; i++)
			push_req(1'b0, addr, body[i], i == n - 1);
	endtask

	// a few fixed devices so that drop counts build up; now and then a
	// stray address that may find the table full
	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h00FF;
			3: return 16'hFF00;
			4: return 16'h5A5A;
			5, 6: return 16'hA5A5;
			7: return 16'h3C3C;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_len();
		int t;
		t = cfg_trailer;
		if (t >= MIN_TRAILER && t <= TRAILER_MAX) begin
			case ($urandom_range(0, 9))
				0: return $urandom_range(1, t);
				1, 2: return t + 1 + $urandom_range(0, 40);
				default: return t + 1 + $urandom_range(0, 6);
			endcase
		end
		return $urandom_range(1, 10);
	endfunction

	// a first response, and after a bad one some rereads: same length,
	// a wrong length, or a failed transfer notice
	task automatic attempt_sequence(logic [15:0] addr);
		int n;
		bit good;
		int r;
		n    = pick_len();
		good = ($urandom_range(0, 3) != 0);
		push_response(addr, n, good);
		if (!good) begin
			for (int j = $urandom_range(0, 3); j > 0; j--) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					good = $urandom_range(0, 1);
					push_response(addr, n, good);
					if (good)
						break;
				end else if (r < 80) begin
					push_response(addr, n + $urandom_range(1, 3), 1'b1);
					break;
				end else begin
					push_req(1'b1, addr, 8'($urandom), 1'($urandom));
					break;
				end
			end
		end
	endtask

	task automatic random_traffic(int n_items, int n_resps);
		logic [15:0] addr;
		int          r;
		phase_items = 0;
		phase_resps = 0;
		while (phase_items < n_items || phase_resps < n_resps) begin
			addr = pick_addr();
			r    = $urandom_range(0, 99);
			if (r < 82)
				attempt_sequence(addr);
			else if (r < 92)
				push_req(1'b1, addr, 8'($urandom), 1'($urandom));
			else
				push_req(1'b0, 16'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Register writes, only while the block is idle
	// ------------------------------------------------------------------
	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_CRC_ENABLE:    cfg_crc_on  = val[0];
			REG_TRAILER_LEN:   cfg_trailer = val[5:0];
			REG_MAX_RETRIES:   cfg_retries = val;
			REG_RECOVER_AFTER: cfg_recover = val;
			default: ;
		endcase
	endtask

	task automatic configure(bit en, int trl, int retries, int recover);
		write_reg(REG_CRC_ENABLE, 8'(en));
		write_reg(REG_TRAILER_LEN, 8'(trl));
		write_reg(REG_MAX_RETRIES, 8'(retries));
		write_reg(REG_RECOVER_AFTER, 8'(recover));
	endtask

	// wait until every request is in and every verdict is out, then let
	// any trailing work on a result-less request finish
	task automatic settle();
		while (bytes_to_send.size() != 0 || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	// ------------------------------------------------------------------
	// Driver: offer the head of the queue at the falling edge; hold it
	// until taken, then advance or go idle
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (arst_n && bytes_to_send.size() != 0 &&
			    $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= bytes_to_send[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			out_stall <= 1'b1;
			holdoff_left--;
		end else if (holdoff_req) begin
			holdoff_req  = 1'b0;
			holdoff_left = HOLDOFF_CYCLES;
			out_stall   <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check the verdict leaving, then predict from the request
	// entering, both at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_channels
		resp_out_t want;
		resp_in_t  req;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result, verdict %0d",
				                          out_data.verdict));
			end else begin
				want = verdicts_due.pop_front();
				check_field("verdict", 32'(out_data.verdict), 32'(want.verdict));
				check_field("payload_len", 32'(out_data.payload_len),
				            32'(want.payload_len));
				check_field("send_recovery", 32'(out_data.send_recovery),
				            32'(want.send_recovery));
				check_field("checked_count", out_data.checked_count, want.checked_count);
				check_field("failed_count", out_data.failed_count, want.failed_count);
				check_field("recovered_count", out_data.recovered_count,
				            want.recovered_count);
				check_field("dropped_count", out_data.dropped_count, want.dropped_count);
				check_field("recovery_count", out_data.recovery_count,
				            want.recovery_count);
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			req       = bytes_to_send.pop_front();
			req_taken = 1'b1;
			if (next_verdict(req, want))
				verdicts_due.push_back(want);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		reset_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// CRC off after reset: a one-byte response passes unchecked, and a
		// failed reread notice with nothing pending is ignored
		set_idling(0, 0);
		push_req(1'b0, 16'hFFFF, 8'hFF, 1'b1);
		push_req(1'b1, 16'hFFFF, 8'h00, 1'b0);
		settle();

		// CRC on, one retry, recover on the first drop
		configure(1'b1, 3, 1, 1);
		push_response(16'hFFFF, 4, 1'b1);
		push_response(16'h0000, 4, 1'b0);
		push_req(1'b1, 16'h0000, 8'h00, 1'b0);
		push_req(1'b1, 16'h0000, 8'hFF, 1'b1);
		push_response(16'h0000, 3, 1'b1);
		push_response(16'h00FF, 4, 1'b0);
		push_response(16'h00FF, 5, 1'b1);
		settle();

		// shortest trailer, no idling
		configure(1'b1, 3, 2, 3);
		random_traffic(130, 15);
		settle();

		// longest trailer and largest counts, sender idle
		configure(1'b1, TRAILER_MAX, 255, 255);
		set_idling(58, 0);
		random_traffic(160, 8);
		settle();

		// receiver stalling; finish on a bad response so a reread is pending
		configure(1'b1, 5, 3, 2);
		set_idling(0, 58);
		random_traffic(120, 12);
		push_response(16'hA5A5, 8, 1'b1);
		push_response(16'h5A5A, 9, 1'b0);
		settle();

		// CRC off abandons the pending reread
		configure(1'b0, 8, 0, 0);
		set_idling(20, 20);
		random_traffic(70, 8);
		settle();

		// trailer below the minimum: everything is too short
		configure(1'b1, 0, 1, 2);
		random_traffic(40, 6);
		settle();

		// trailer above the tail store
		configure(1'b1, 63, 4, 2);
		set_idling(58, 0);
		random_traffic(30, 5);
		settle();

		// hold the receiver off while the sender keeps offering requests
		configure(1'b1, 4, 1, 2);
		set_idling(0, 0);
		random_traffic(110, 15);
		holdoff_req = 1'b1;
		settle();

		// oversized responses, checked and unchecked
		configure(1'b1, 3, 0, 0);
		push_response(16'hFFFF, RESPONSE_MAX + 3, 1'b1);
		push_response(16'h0000, 5, 1'b1);
		settle();
		write_reg(REG_CRC_ENABLE, 8'd0);
		push_response(16'h00FF, RESPONSE_MAX + 6, 1'b1);
		push_response(16'hFF00, 2, 1'b1);
		settle();

		if (mismatch_count == 0 && verdicts_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
